### rtl/core/csv_record_splitter_macros.svh
// Assertion macros shared by the CSV record splitter.
// Both forms expand to nothing when SYNTHESIS is defined.
`ifndef CSV_RECORD_SPLITTER_MACROS_SVH
`define CSV_RECORD_SPLITTER_MACROS_SVH
`ifndef SYNTHESIS
// Whenever a holds, b holds in the same cycle.
`define CSV_RS_ASSERT_IMP(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("csv_rs: assertion failed");
// Whenever a holds, b holds in the next cycle.
`define CSV_RS_ASSERT_NXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("csv_rs: assertion failed");
`else
`define CSV_RS_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define CSV_RS_ASSERT_NXT(lbl, clk, rst_n, a, b)
`endif
`endif

### rtl/core/csv_rs_pkg.sv
package csv_rs_pkg;

  localparam int OFFSET_BITS  = 48;
  localparam int FIELD_BITS   = 10;
  localparam int MAX_FIELDS   = 1023;
  localparam int RECNUM_BITS  = 32;
  localparam int CFG_DATA_BITS = 16;
  localparam int CMD_DEPTH    = 4;
  localparam int CMD_PTR_BITS = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_BITS = $clog2(CMD_DEPTH + 1);

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Result kinds.
  localparam logic [1:0] KIND_CONTENT   = 2'd0;
  localparam logic [1:0] KIND_FIELD_END = 2'd1;
  localparam logic [1:0] KIND_DONE      = 2'd2;
  localparam logic [1:0] KIND_ERROR     = 2'd3;

  // Error codes.
  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_OPEN_QUOTE   = 3'd1;
  localparam logic [2:0] ERR_PAST_QUOTE   = 3'd2;
  localparam logic [2:0] ERR_STRAY_QUOTE  = 3'd3;
  localparam logic [2:0] ERR_HDR_TOO_LONG = 3'd4;
  localparam logic [2:0] ERR_NO_HEADER    = 3'd5;

  // Configuration register indexes.
  localparam logic CFG_HEADER_PRESENT = 1'b0;
  localparam logic CFG_HDR_LIMIT      = 1'b1;

  typedef enum logic [2:0] {
    CLS_QUOTE,
    CLS_COMMA,
    CLS_CR,
    CLS_LF,
    CLS_OTHER,
    CLS_EOI
  } class_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic [7:0]             content_byte;
    logic                   is_header;
    logic [FIELD_BITS-1:0]  num_fields;
    logic [OFFSET_BITS-1:0] record_begin;
    logic [OFFSET_BITS-1:0] record_end;
    logic [RECNUM_BITS-1:0] record_number;
    logic [2:0]             error_code;
  } out_item_t;

  typedef struct packed {
    class_e     cls;
    logic [7:0] byte_value;
  } cmd_t;

  typedef struct packed {
    logic        header_present;
    logic [15:0] hdr_byte_limit;
  } cfg_t;

endpackage

### rtl/core/csv_rs_front.sv
module csv_rs_front (
  input  logic                 push_i,
  input  csv_rs_pkg::in_item_t item_i,
  input  logic                 queue_full_i,
  output logic                 wr_en_o,
  output csv_rs_pkg::cmd_t     cmd_o
);

  csv_rs_pkg::class_e cls;

  // Reduce each byte to the class that the tokenizer acts on.
  always_comb begin
    if (item_i.end_of_input) begin
      cls = csv_rs_pkg::CLS_EOI;
    end else begin
      case (item_i.byte_value)
        csv_rs_pkg::CH_QUOTE: cls = csv_rs_pkg::CLS_QUOTE;
        csv_rs_pkg::CH_COMMA: cls = csv_rs_pkg::CLS_COMMA;
        csv_rs_pkg::CH_CR:    cls = csv_rs_pkg::CLS_CR;
        csv_rs_pkg::CH_LF:    cls = csv_rs_pkg::CLS_LF;
        default:              cls = csv_rs_pkg::CLS_OTHER;
      endcase
    end
  end

  assign wr_en_o          = push_i && !queue_full_i;
  assign cmd_o.cls        = cls;
  assign cmd_o.byte_value = item_i.byte_value;

endmodule

### rtl/core/csv_rs_cmd_fifo.sv
module csv_rs_cmd_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  csv_rs_pkg::cmd_t wr_cmd_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output logic             valid_o,
  output csv_rs_pkg::cmd_t rd_cmd_o
);

  csv_rs_pkg::cmd_t                      mem_q [csv_rs_pkg::CMD_DEPTH];
  logic [csv_rs_pkg::CMD_PTR_BITS-1:0]   wr_ptr_q, wr_ptr_d;
  logic [csv_rs_pkg::CMD_PTR_BITS-1:0]   rd_ptr_q, rd_ptr_d;
  logic [csv_rs_pkg::CMD_CNT_BITS-1:0]   cnt_q, cnt_d;
  logic                                  do_rd;

  assign full_o   = (cnt_q == csv_rs_pkg::CMD_CNT_BITS'(csv_rs_pkg::CMD_DEPTH));
  assign valid_o  = (cnt_q != '0);
  assign rd_cmd_o = mem_q[rd_ptr_q];
  assign do_rd    = rd_en_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_en_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_rd ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en_i && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_en_i && do_rd) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

endmodule

### rtl/core/csv_rs_back.sv
module csv_rs_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  csv_rs_pkg::cfg_t      cfg_i,
  input  logic                  cmd_valid_i,
  input  csv_rs_pkg::cmd_t      cmd_i,
  output logic                  cmd_rd_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output csv_rs_pkg::out_item_t item_o
);

  localparam int OB = csv_rs_pkg::OFFSET_BITS;
  localparam int FB = csv_rs_pkg::FIELD_BITS;

  localparam logic [1:0] PH_START    = 2'd0;
  localparam logic [1:0] PH_UNQUOTED = 2'd1;
  localparam logic [1:0] PH_QUOTED   = 2'd2;
  localparam logic [1:0] PH_AFTER    = 2'd3;

  logic [1:0]                         phase_q, phase_d;
  logic [OB-1:0]                      cursor_q, cursor_d;
  logic [OB-1:0]                      begin_q, begin_d;
  logic                               has_bytes_q, has_bytes_d;
  logic [FB-1:0]                      fields_q, fields_d;
  logic                               swallow_q, swallow_d;
  logic                               hdr_seen_q, hdr_seen_d;
  logic [csv_rs_pkg::RECNUM_BITS-1:0] records_q, records_d;
  logic                               halted_q, halted_d;

  csv_rs_pkg::out_item_t slot0_q, slot1_q, res;
  logic [1:0]            ocnt_q;
  logic                  out_pop, room, take, produce, fin, hdr, is_term;
  logic [OB-1:0]         cur_n, fin_end, rec_len;
  logic [FB-1:0]         fields_inc;

  assign out_pop  = pop_i && (ocnt_q != 2'd0);
  assign room     = (ocnt_q != 2'd2) || out_pop;
  assign take     = cmd_valid_i && room;
  assign cmd_rd_o = take;
  assign empty_o  = (ocnt_q == 2'd0);
  assign item_o   = slot0_q;

  assign hdr        = cfg_i.header_present && !hdr_seen_q;
  assign cur_n      = cursor_q + 1'b1;
  assign rec_len    = cur_n - begin_q;
  assign fields_inc = (fields_q < FB'(csv_rs_pkg::MAX_FIELDS)) ? fields_q + 1'b1 : fields_q;
  assign is_term    = (cmd_i.cls == csv_rs_pkg::CLS_COMMA) || (cmd_i.cls == csv_rs_pkg::CLS_CR)
                   || (cmd_i.cls == csv_rs_pkg::CLS_LF);

  always_comb begin
    phase_d     = phase_q;
    cursor_d    = cursor_q;
    begin_d     = begin_q;
    has_bytes_d = has_bytes_q;
    fields_d    = fields_q;
    swallow_d   = swallow_q;
    hdr_seen_d  = hdr_seen_q;
    records_d   = records_q;
    halted_d    = halted_q;
    res         = '0;
    produce     = 1'b0;
    fin         = 1'b0;
    fin_end     = cursor_q;

    if (take && !halted_q) begin
      if (cmd_i.cls == csv_rs_pkg::CLS_EOI) begin
        swallow_d = 1'b0;
        if (!has_bytes_q) begin
          if (hdr) begin
            res.kind       = csv_rs_pkg::KIND_ERROR;
            res.error_code = csv_rs_pkg::ERR_NO_HEADER;
            produce        = 1'b1;
            halted_d       = 1'b1;
          end
        end else if (phase_q == PH_QUOTED) begin
          res.kind       = csv_rs_pkg::KIND_ERROR;
          res.error_code = csv_rs_pkg::ERR_OPEN_QUOTE;
          produce        = 1'b1;
          halted_d       = 1'b1;
        end else begin
          fin = 1'b1;
        end
      end else if (swallow_q && (cmd_i.cls == csv_rs_pkg::CLS_LF)) begin
        // Line feed of a CR LF pair: it only moves the offsets on.
        swallow_d = 1'b0;
        cursor_d  = cur_n;
        begin_d   = cur_n;
      end else begin
        swallow_d   = 1'b0;
        has_bytes_d = 1'b1;
        cursor_d    = cur_n;
        if (hdr && (rec_len > OB'(cfg_i.hdr_byte_limit))) begin
          res.kind       = csv_rs_pkg::KIND_ERROR;
          res.error_code = csv_rs_pkg::ERR_HDR_TOO_LONG;
          produce        = 1'b1;
          halted_d       = 1'b1;
        end else begin
          unique case (phase_q)
            PH_QUOTED: begin
              if (cmd_i.cls == csv_rs_pkg::CLS_QUOTE) begin
                phase_d = PH_AFTER;
              end else if (hdr) begin
                res.kind         = csv_rs_pkg::KIND_CONTENT;
                res.content_byte = cmd_i.byte_value;
                produce          = 1'b1;
              end
            end
            PH_AFTER: begin
              if (cmd_i.cls == csv_rs_pkg::CLS_QUOTE) begin
                // Doubled quote inside a quoted field.
                phase_d = PH_QUOTED;
                if (hdr) begin
                  res.kind         = csv_rs_pkg::KIND_CONTENT;
                  res.content_byte = cmd_i.byte_value;
                  produce          = 1'b1;
                end
              end else if (!is_term) begin
                res.kind       = csv_rs_pkg::KIND_ERROR;
                res.error_code = csv_rs_pkg::ERR_PAST_QUOTE;
                produce        = 1'b1;
                halted_d       = 1'b1;
              end
            end
            default: begin
              if (cmd_i.cls == csv_rs_pkg::CLS_QUOTE) begin
                if (phase_q != PH_START) begin
                  res.kind       = csv_rs_pkg::KIND_ERROR;
                  res.error_code = csv_rs_pkg::ERR_STRAY_QUOTE;
                  produce        = 1'b1;
                  halted_d       = 1'b1;
                end else begin
                  phase_d = PH_QUOTED;
                end
              end else if (!is_term) begin
                phase_d = PH_UNQUOTED;
                if (hdr) begin
                  res.kind         = csv_rs_pkg::KIND_CONTENT;
                  res.content_byte = cmd_i.byte_value;
                  produce          = 1'b1;
                end
              end
            end
          endcase

          // Terminators close a field, or a record, unless inside quotes or an error fired above.
          if (is_term && !halted_d && !(phase_q == PH_QUOTED)) begin
            if (cmd_i.cls == csv_rs_pkg::CLS_COMMA) begin
              fields_d = fields_inc;
              phase_d  = PH_START;
              if (hdr) begin
                res.kind = csv_rs_pkg::KIND_FIELD_END;
                produce  = 1'b1;
              end
            end else begin
              swallow_d = (cmd_i.cls == csv_rs_pkg::CLS_CR);
              fin       = 1'b1;
              fin_end   = cursor_q;
            end
          end
        end
      end

      if (fin) begin
        res.kind         = csv_rs_pkg::KIND_DONE;
        res.is_header    = hdr;
        res.num_fields   = fields_inc;
        res.record_begin = begin_q;
        res.record_end   = fin_end;
        produce          = 1'b1;
        if (hdr) begin
          hdr_seen_d = 1'b1;
        end else begin
          res.record_number = records_q;
          records_d         = records_q + 1'b1;
        end
        phase_d     = PH_START;
        has_bytes_d = 1'b0;
        fields_d    = '0;
        begin_d     = cursor_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      cursor_q    <= '0;
      begin_q     <= '0;
      has_bytes_q <= 1'b0;
      fields_q    <= '0;
      swallow_q   <= 1'b0;
      hdr_seen_q  <= 1'b0;
      records_q   <= '0;
      halted_q    <= 1'b0;
      ocnt_q      <= 2'd0;
    end else begin
      phase_q     <= phase_d;
      cursor_q    <= cursor_d;
      begin_q     <= begin_d;
      has_bytes_q <= has_bytes_d;
      fields_q    <= fields_d;
      swallow_q   <= swallow_d;
      hdr_seen_q  <= hdr_seen_d;
      records_q   <= records_d;
      halted_q    <= halted_d;
      ocnt_q      <= ocnt_q + {1'b0, produce} - {1'b0, out_pop};
    end
  end

  // Two-entry result queue; slot0 is the head.
  always_ff @(posedge clk_i) begin
    if (out_pop && (ocnt_q == 2'd2)) begin
      slot0_q <= slot1_q;
    end
    if (produce) begin
      if ((ocnt_q == 2'd0) || (out_pop && (ocnt_q == 2'd1))) begin
        slot0_q <= res;
      end else begin
        slot1_q <= res;
      end
    end
  end

endmodule

### rtl/core/csv_record_splitter.sv
// CSV record splitter: one byte or end marker per item, one item per cycle while results drain.
// Accepted items wait in the command queue; each result is registered into the result queue.
// Throughput: one item every cycle while results are taken; the tokenizer state loop decides.
// A four-entry command queue and a two-entry result queue let either side stall on its own.
// Reset (rst_ni, asynchronous, active low) clears all control state and loads the
// configuration defaults: header present, maximum header size 4096 bytes.
module csv_record_splitter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  input  csv_rs_pkg::in_item_t                 in_item_i,
  output logic                                 full,
  input  logic                                 pop,
  output logic                                 empty,
  output csv_rs_pkg::out_item_t                out_item_o,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_idx_i,
  input  logic [csv_rs_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);

`include "csv_record_splitter_macros.svh"

  // Configuration registers. The user must see that they are only written while the
  // block is idle, so the tokenizer can read them directly; the block does not enforce it.
  csv_rs_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        csv_rs_pkg::CFG_HEADER_PRESENT: cfg_d.header_present = cfg_data_i[0];
        csv_rs_pkg::CFG_HDR_LIMIT:      cfg_d.hdr_byte_limit = cfg_data_i[15:0];
        default:                        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_present <= 1'b1;
      cfg_q.hdr_byte_limit <= 16'd4096;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end: classifies each incoming item and writes it to the command queue.
  logic             cmd_wr;
  csv_rs_pkg::cmd_t cmd_wr_data;

  csv_rs_front u_front (
    .push_i       (push),
    .item_i       (in_item_i),
    .queue_full_i (full),
    .wr_en_o      (cmd_wr),
    .cmd_o        (cmd_wr_data)
  );

  // Command queue between the classifier and the tokenizer.
  logic             cmd_rd;
  logic             cmd_valid;
  csv_rs_pkg::cmd_t cmd_rd_data;

  csv_rs_cmd_fifo u_cmd_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (cmd_wr),
    .wr_cmd_i (cmd_wr_data),
    .full_o   (full),
    .rd_en_i  (cmd_rd),
    .valid_o  (cmd_valid),
    .rd_cmd_o (cmd_rd_data)
  );

  // Back end: the tokenizer state machine. It takes one queued item per cycle
  // whenever its result queue has room, and writes at most one result item.
  // After an error it keeps draining items but produces nothing more.
  csv_rs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_rd_data),
    .cmd_rd_o    (cmd_rd),
    .pop_i       (pop),
    .empty_o     (empty),
    .item_o      (out_item_o)
  );

  // Whether the head result item is an error, and whether its code is zero.
  logic head_is_err;
  logic code_zero;

  assign head_is_err = !empty && (out_item_o.kind == csv_rs_pkg::KIND_ERROR);
  assign code_zero   = (out_item_o.error_code == csv_rs_pkg::ERR_NONE);

  // An error result always carries a nonzero code, and no other result does.
  `CSV_RS_ASSERT_IMP(a_err_code, clk_i, rst_ni, head_is_err, !code_zero)
  `CSV_RS_ASSERT_IMP(a_no_code, clk_i, rst_ni, !empty && !head_is_err, code_zero)
  // The header record is not numbered.
  `CSV_RS_ASSERT_IMP(a_hdr_num, clk_i, rst_ni, !empty && out_item_o.is_header, ~|out_item_o.record_number)
  // An error is the last result item: once it is taken, the result queue stays empty.
  `CSV_RS_ASSERT_NXT(a_err_last, clk_i, rst_ni, pop && head_is_err, empty)

endmodule

### bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // A watchdog trips after this many cycles in which no item moves on either side.
  localparam int WATCHDOG_LIMIT = 4000;
  // Quiet cycles after the last due result, to let the pipeline settle.
  localparam int SETTLE_CYCLES  = 16;

  typedef enum logic [1:0] {
    AT_FIELD_START,
    IN_UNQUOTED,
    IN_QUOTED,
    PAST_QUOTE
  } field_phase_e;

  typedef enum int {
    EMPTY_FIELD,
    PLAIN_FIELD,
    QUOTED_FIELD
  } field_shape_e;

  typedef enum int {
    TERM_LF,
    TERM_CR,
    TERM_CRLF,
    TERM_EOI
  } record_term_e;

  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 push;
  csv_rs_pkg::in_item_t                 in_item_i;
  logic                                 full;
  logic                                 pop;
  logic                                 empty;
  csv_rs_pkg::out_item_t                out_item_o;
  logic                                 cfg_we_i;
  logic                                 cfg_idx_i;
  logic [csv_rs_pkg::CFG_DATA_BITS-1:0] cfg_data_i;

  csv_record_splitter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .in_item_i  (in_item_i),
    .full       (full),
    .pop        (pop),
    .empty      (empty),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Tokenizer state as the block holds it, starting from its reset values.
  bit                                 hdr_enable    = 1'b1;
  logic [15:0]                        hdr_limit     = 16'd4096;
  field_phase_e                       phase         = AT_FIELD_START;
  logic [csv_rs_pkg::OFFSET_BITS-1:0] cursor        = '0;
  logic [csv_rs_pkg::OFFSET_BITS-1:0] rec_begin     = '0;
  bit                                 rec_has_bytes = 1'b0;
  logic [csv_rs_pkg::FIELD_BITS-1:0]  field_cnt     = '0;
  bit                                 lf_pending    = 1'b0;
  bit                                 header_done   = 1'b0;
  logic [csv_rs_pkg::RECNUM_BITS-1:0] rec_count     = '0;
  bit                                 halted        = 1'b0;

  // Tokens the block owes us, oldest first.
  csv_rs_pkg::out_item_t due_tokens[$];
  // Record being assembled before it is streamed in.
  csv_rs_pkg::in_item_t  staged_items[$];

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   items_sent     = 0;
  int   mismatch_count = 0;
  int   quiet_cycles   = 0;
  logic [2:0] closing_error;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Tokenizer prediction. Each accepted item advances the state below and may
  // queue one token: a header content byte, a header field end, a finished
  // record or an error.
  // ---------------------------------------------------------------------------

  function automatic bit is_delimiter(input logic [7:0] b);
    return (b == csv_rs_pkg::CH_COMMA) || (b == csv_rs_pkg::CH_CR) || (b == csv_rs_pkg::CH_LF);
  endfunction

  function automatic void owe_token(input csv_rs_pkg::out_item_t tok);
    due_tokens = {due_tokens, tok};
  endfunction

  function automatic void stage_item(input csv_rs_pkg::in_item_t it);
    staged_items = {staged_items, it};
  endfunction

  function automatic void bump_field_count();
    if (field_cnt < csv_rs_pkg::MAX_FIELDS) field_cnt++;
  endfunction

  function automatic void queue_token(input logic [1:0] kind, input logic [7:0] b);
    csv_rs_pkg::out_item_t tok;
    tok = '0;
    tok.kind = kind;
    tok.content_byte = b;
    owe_token(tok);
  endfunction

  // Any error halts the tokenizer for good.
  function automatic void queue_error(input logic [2:0] code);
    csv_rs_pkg::out_item_t tok;
    tok = '0;
    tok.kind = csv_rs_pkg::KIND_ERROR;
    tok.error_code = code;
    owe_token(tok);
    halted = 1'b1;
  endfunction

  // The last field is counted here; header records carry no record number.
  function automatic void close_record(input logic [csv_rs_pkg::OFFSET_BITS-1:0] rec_end,
                                       input bit as_header);
    csv_rs_pkg::out_item_t tok;
    bump_field_count();
    tok = '0;
    tok.kind = csv_rs_pkg::KIND_DONE;
    tok.is_header = as_header;
    tok.num_fields = field_cnt;
    tok.record_begin = rec_begin;
    tok.record_end = rec_end;
    if (as_header) begin
      header_done = 1'b1;
    end else begin
      tok.record_number = rec_count;
      rec_count++;
    end
    owe_token(tok);
    phase = AT_FIELD_START;
    rec_has_bytes = 1'b0;
    field_cnt = '0;
    rec_begin = cursor;
  endfunction

  function automatic void tokenize_byte(input csv_rs_pkg::in_item_t item);
    logic [7:0]                         b;
    logic [csv_rs_pkg::OFFSET_BITS-1:0] span;
    bit                                 in_header;
    b = item.byte_value;
    in_header = hdr_enable && !header_done;
    if (halted) return;

    if (item.end_of_input) begin
      lf_pending = 1'b0;
      if (!rec_has_bytes) begin
        // Nothing pending: silent, unless the header never came.
        if (in_header) queue_error(csv_rs_pkg::ERR_NO_HEADER);
      end else if (phase == IN_QUOTED) begin
        queue_error(csv_rs_pkg::ERR_OPEN_QUOTE);
      end else begin
        close_record(cursor, in_header);
      end
      return;
    end

    // A line feed right after a CR terminator belongs to that terminator.
    if (lf_pending) begin
      lf_pending = 1'b0;
      if (b == csv_rs_pkg::CH_LF) begin
        cursor = cursor + 1'b1;
        rec_begin = cursor;
        return;
      end
    end

    rec_has_bytes = 1'b1;
    cursor = cursor + 1'b1;
    span = cursor - rec_begin;
    if (in_header && span > {{(csv_rs_pkg::OFFSET_BITS-16){1'b0}}, hdr_limit}) begin
      queue_error(csv_rs_pkg::ERR_HDR_TOO_LONG);
      return;
    end

    case (phase)
      IN_QUOTED: begin
        if (b == csv_rs_pkg::CH_QUOTE) phase = PAST_QUOTE;
        else if (in_header) queue_token(csv_rs_pkg::KIND_CONTENT, b);
        return;
      end
      PAST_QUOTE: begin
        // A second quote is an escaped quote; only a delimiter may follow otherwise.
        if (b == csv_rs_pkg::CH_QUOTE) begin
          phase = IN_QUOTED;
          if (in_header) queue_token(csv_rs_pkg::KIND_CONTENT, b);
          return;
        end
        if (!is_delimiter(b)) begin
          queue_error(csv_rs_pkg::ERR_PAST_QUOTE);
          return;
        end
      end
      default: begin
        if (b == csv_rs_pkg::CH_QUOTE) begin
          if (phase != AT_FIELD_START) queue_error(csv_rs_pkg::ERR_STRAY_QUOTE);
          else phase = IN_QUOTED;
          return;
        end
        if (!is_delimiter(b)) begin
          phase = IN_UNQUOTED;
          if (in_header) queue_token(csv_rs_pkg::KIND_CONTENT, b);
          return;
        end
      end
    endcase

    if (b == csv_rs_pkg::CH_COMMA) begin
      bump_field_count();
      phase = AT_FIELD_START;
      if (in_header) queue_token(csv_rs_pkg::KIND_FIELD_END, 8'h00);
      return;
    end
    if (b == csv_rs_pkg::CH_CR) lf_pending = 1'b1;
    close_record(cursor - 1'b1, in_header);
  endfunction

  // ---------------------------------------------------------------------------
  // Item construction.
  // ---------------------------------------------------------------------------

  function automatic csv_rs_pkg::in_item_t stream_byte(input logic [7:0] b);
    csv_rs_pkg::in_item_t it;
    it.byte_value = b;
    it.end_of_input = 1'b0;
    return it;
  endfunction

  // The byte that rides along with an end marker is ignored, so it is random.
  function automatic csv_rs_pkg::in_item_t end_marker();
    csv_rs_pkg::in_item_t it;
    it.byte_value = $urandom_range(0, 255);
    it.end_of_input = 1'b1;
    return it;
  endfunction

  // A byte that may stand anywhere in an unquoted field.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = $urandom_range(0, 255);
    while (b == csv_rs_pkg::CH_QUOTE || is_delimiter(b)) b = $urandom_range(0, 255);
    return b;
  endfunction

  // Quoted content leans on the bytes that matter to the tokenizer.
  function automatic logic [7:0] quoted_byte();
    logic [7:0] pick;
    if ($urandom_range(0, 3) != 0) return $urandom_range(0, 255);
    case ($urandom_range(0, 3))
      0:       pick = csv_rs_pkg::CH_QUOTE;
      1:       pick = csv_rs_pkg::CH_COMMA;
      2:       pick = csv_rs_pkg::CH_CR;
      default: pick = csv_rs_pkg::CH_LF;
    endcase
    return pick;
  endfunction

  // Raw header size as the block counts it: the LF of a CR LF is not counted.
  function automatic int header_raw_length();
    int n;
    n = staged_items.size();
    if (n >= 2 && staged_items[n-1].byte_value == csv_rs_pkg::CH_LF &&
        staged_items[n-2].byte_value == csv_rs_pkg::CH_CR) n--;
    return n;
  endfunction

  // Builds one well-formed record into staged_items.
  task automatic build_record(input int n_fields, input bit end_ok, input bit first_filled);
    int           f;
    int           len;
    logic [7:0]   c;
    field_shape_e shape;
    record_term_e term;
    staged_items.delete();
    for (f = 0; f < n_fields; f++) begin
      if (f != 0) stage_item(stream_byte(csv_rs_pkg::CH_COMMA));
      if (f == 0 && first_filled) shape = field_shape_e'($urandom_range(PLAIN_FIELD, QUOTED_FIELD));
      else shape = field_shape_e'($urandom_range(EMPTY_FIELD, QUOTED_FIELD));
      case (shape)
        PLAIN_FIELD: begin
          len = $urandom_range(1, 8);
          repeat (len) stage_item(stream_byte(plain_byte()));
        end
        QUOTED_FIELD: begin
          stage_item(stream_byte(csv_rs_pkg::CH_QUOTE));
          len = $urandom_range(0, 8);
          repeat (len) begin
            c = quoted_byte();
            stage_item(stream_byte(c));
            // A quote inside quotes is written twice.
            if (c == csv_rs_pkg::CH_QUOTE) stage_item(stream_byte(csv_rs_pkg::CH_QUOTE));
          end
          stage_item(stream_byte(csv_rs_pkg::CH_QUOTE));
        end
        default: ;
      endcase
    end
    term = record_term_e'($urandom_range(TERM_LF, end_ok ? TERM_EOI : TERM_CRLF));
    case (term)
      TERM_LF:   stage_item(stream_byte(csv_rs_pkg::CH_LF));
      TERM_CR:   stage_item(stream_byte(csv_rs_pkg::CH_CR));
      TERM_CRLF: begin
        stage_item(stream_byte(csv_rs_pkg::CH_CR));
        stage_item(stream_byte(csv_rs_pkg::CH_LF));
      end
      default:   stage_item(end_marker());
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driving. Push is left high after an accepted item, so that back-to-back
  // items keep it high; it drops only for idle cycles and before a drain.
  // ---------------------------------------------------------------------------

  task automatic send_item(input csv_rs_pkg::in_item_t item);
    csv_rs_pkg::in_item_t noise;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      noise = $urandom_range(0, 511);
      push <= 1'b0;
      in_item_i <= noise;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_item_i <= item;
    // Full is sampled as it stood before the edge.
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    tokenize_byte(item);
    items_sent++;
  endtask

  task automatic send_staged();
    foreach (staged_items[i]) send_item(staged_items[i]);
  endtask

  // Waits until every due token has been taken, then lets the pipeline settle.
  task automatic drain_results();
    push <= 1'b0;
    while (due_tokens.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Only called while the block is idle.
  task automatic write_reg(input logic idx, input logic [csv_rs_pkg::CFG_DATA_BITS-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == csv_rs_pkg::CFG_HEADER_PRESENT) hdr_enable = data[0];
    else hdr_limit = data;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: pop stalls at random, and each accepted result is checked
  // against the oldest due token.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) pop <= ($urandom_range(0, 99) >= recv_stall_pct);

  task automatic report_mismatch(input string what);
    if (mismatch_count < 100) $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  always @(posedge clk_i) begin : result_check
    csv_rs_pkg::out_item_t want;
    if (rst_ni && pop && !empty) begin
      if (due_tokens.size() == 0) begin
        report_mismatch($sformatf("result item of kind %0d with none due", out_item_o.kind));
      end else begin
        want = due_tokens.pop_front();
        check_field("kind", out_item_o.kind, want.kind);
        check_field("content_byte", out_item_o.content_byte, want.content_byte);
        check_field("is_header", out_item_o.is_header, want.is_header);
        check_field("num_fields", out_item_o.num_fields, want.num_fields);
        check_field("record_begin", out_item_o.record_begin, want.record_begin);
        check_field("record_end", out_item_o.record_end, want.record_end);
        check_field("record_number", out_item_o.record_number, want.record_number);
        check_field("error_code", out_item_o.error_code, want.error_code);
      end
    end
  end

  // The watchdog restarts whenever an item moves through either port.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("csv_record_splitter verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Hand-written data records: quoting, escapes, every terminator, empty
  // lines, end markers with and without a pending record, and byte extremes.
  task automatic test_directed_records();
    write_reg(csv_rs_pkg::CFG_HEADER_PRESENT, '0);
    write_reg(csv_rs_pkg::CFG_HDR_LIMIT, 16'd1);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // a,b LF
    send_item(stream_byte(8'h61));
    send_item(stream_byte(csv_rs_pkg::CH_COMMA));
    send_item(stream_byte(8'h62));
    send_item(stream_byte(csv_rs_pkg::CH_LF));
    // A quoted comma, an escaped quote, CR and LF inside quotes, then CR LF.
    send_item(stream_byte(csv_rs_pkg::CH_QUOTE));
    send_item(stream_byte(csv_rs_pkg::CH_COMMA));
    send_item(stream_byte(csv_rs_pkg::CH_QUOTE));
    send_item(stream_byte(csv_rs_pkg::CH_QUOTE));
    send_item(stream_byte(csv_rs_pkg::CH_CR));
    send_item(stream_byte(csv_rs_pkg::CH_LF));
    send_item(stream_byte(csv_rs_pkg::CH_QUOTE));
    send_item(stream_byte(csv_rs_pkg::CH_CR));
    send_item(stream_byte(csv_rs_pkg::CH_LF));
    // An empty line is a record of one empty field.
    send_item(stream_byte(csv_rs_pkg::CH_LF));
    // Two empty fields closed by the end marker, then an end with nothing pending.
    send_item(stream_byte(csv_rs_pkg::CH_COMMA));
    send_item(end_marker());
    send_item(end_marker());
    // Extreme byte values after the end marker start a new record, ended by CR.
    send_item(stream_byte(8'hFF));
    send_item(stream_byte(8'h00));
    send_item(stream_byte(csv_rs_pkg::CH_CR));
    // An empty quoted field; its opening quote drops the pending CR state, the end marker closes it.
    send_item(stream_byte(csv_rs_pkg::CH_QUOTE));
    send_item(stream_byte(csv_rs_pkg::CH_QUOTE));
    send_item(end_marker());
    drain_results();
  endtask

  // More fields than the count can reach: the count must stick at its top.
  task automatic test_field_count_saturation();
    staged_items.delete();
    stage_item(stream_byte(8'h61));
    repeat (csv_rs_pkg::MAX_FIELDS + 7) stage_item(stream_byte(csv_rs_pkg::CH_COMMA));
    stage_item(stream_byte(csv_rs_pkg::CH_LF));
    send_staged();
    drain_results();
  endtask

  // Mostly well-formed records with random content, some wide ones, and
  // stray end markers between records as noise.
  task automatic test_random_records(input int n_items, input int send_pct, input int recv_pct);
    int first;
    int n_fields;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    first = items_sent;
    while (items_sent - first < n_items) begin
      if ($urandom_range(0, 7) == 0) send_item(end_marker());
      n_fields = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 30) : $urandom_range(1, 6);
      build_record(n_fields, 1'b1, 1'b0);
      send_staged();
    end
    drain_results();
  endtask

  // The header comes at most once per run. Its limit is either the widest setting or
  // exactly its raw size, which puts the terminator right on the boundary.
  task automatic test_header_record();
    int raw_len;
    build_record($urandom_range(1, 6), 1'b0, 1'b1);
    raw_len = header_raw_length();
    write_reg(csv_rs_pkg::CFG_HDR_LIMIT, $urandom_range(0, 1) ? 16'hFFFF : raw_len[15:0]);
    write_reg(csv_rs_pkg::CFG_HEADER_PRESENT, 1'b1);
    send_staged();
    drain_results();
    // The header has been seen, so this setting must change nothing from here on.
    write_reg(csv_rs_pkg::CFG_HEADER_PRESENT, $urandom_range(0, 1));
  endtask

  // Errors are sticky and reset comes only once, so one run ends in one of
  // them; the seed picks which. Items sent afterwards must yield nothing.
  task automatic test_sticky_error(input logic [2:0] code);
    int raw_len;
    int len;
    logic [7:0] c;
    case (code)
      csv_rs_pkg::ERR_OPEN_QUOTE: begin
        send_item(stream_byte(csv_rs_pkg::CH_QUOTE));
        len = $urandom_range(0, 6);
        repeat (len) begin
          c = quoted_byte();
          if (c == csv_rs_pkg::CH_QUOTE) c = csv_rs_pkg::CH_COMMA;
          send_item(stream_byte(c));
        end
        send_item(end_marker());
      end
      csv_rs_pkg::ERR_PAST_QUOTE: begin
        send_item(stream_byte(csv_rs_pkg::CH_QUOTE));
        send_item(stream_byte(plain_byte()));
        send_item(stream_byte(csv_rs_pkg::CH_QUOTE));
        send_item(stream_byte(plain_byte()));
      end
      csv_rs_pkg::ERR_STRAY_QUOTE: begin
        send_item(stream_byte(plain_byte()));
        send_item(stream_byte(csv_rs_pkg::CH_QUOTE));
      end
      csv_rs_pkg::ERR_HDR_TOO_LONG: begin
        // Header content flows out until the byte that crosses the limit.
        build_record($urandom_range(1, 6), 1'b0, 1'b1);
        raw_len = header_raw_length();
        write_reg(csv_rs_pkg::CFG_HDR_LIMIT, $urandom_range(0, raw_len - 1));
        write_reg(csv_rs_pkg::CFG_HEADER_PRESENT, 1'b1);
        send_staged();
      end
      default: begin
        // The stream ends at a record boundary while the header is still awaited.
        write_reg(csv_rs_pkg::CFG_HEADER_PRESENT, 1'b1);
        send_item(end_marker());
      end
    endcase
    repeat (20) send_item(csv_rs_pkg::in_item_t'($urandom_range(0, 511)));
    drain_results();
  endtask

  initial begin
    push <= 1'b0;
    pop <= 1'b0;
    in_item_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= csv_rs_pkg::CFG_HEADER_PRESENT;
    cfg_data_i <= '0;
    rst_ni <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Errors four and five need a header that has not come yet, so those
    // runs skip the header record test.
    closing_error = $urandom_range(csv_rs_pkg::ERR_OPEN_QUOTE, csv_rs_pkg::ERR_NO_HEADER);

    test_directed_records();
    test_field_count_saturation();
    test_random_records(110, 0, 0);
    write_reg(csv_rs_pkg::CFG_HDR_LIMIT, 16'hFFFF);
    test_random_records(110, 73, 0);
    if (closing_error != csv_rs_pkg::ERR_HDR_TOO_LONG &&
        closing_error != csv_rs_pkg::ERR_NO_HEADER) begin
      test_header_record();
    end
    test_random_records(110, 0, 73);
    test_random_records(110, 33, 33);
    test_sticky_error(closing_error);

    if (mismatch_count == 0 && due_tokens.size() == 0) begin
      $display("csv_record_splitter verification clean");
    end else begin
      $display("csv_record_splitter verification failed");
    end
    $finish;
  end

endmodule
